/* src/lcabl_pkg.sv */
// Shared types and constants of the lowest-common-ancestor block.
// Used by lcabl_ctrl, lcabl_datapath and lca_binary_lifting; depends on nothing.
package lcabl_pkg;

	localparam int NODE_W = 10;
	localparam int ENTRY_W = NODE_W + 1;
	localparam int DEPTH_W = 10;
	localparam int PATH_W = 11;
	localparam int DIST_W = 10;
	localparam int LVL_W = 5;
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 10'd1023;

	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_JUMP_LEVELS = 10;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Micro-operation carried out by the datapath.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_L_RD,
		OP_L_CHK,
		OP_L_STEP,
		OP_L_NEXT,
		OP_Q_RDA,
		OP_Q_RDB,
		OP_Q_CHK,
		OP_SCAN,
		OP_APPLY,
		OP_LIFT_END,
		OP_DESC_U,
		OP_DESC_V,
		OP_DESC_CMP,
		OP_FIN_RD,
		OP_FIN,
		OP_DL_RD,
		OP_DL,
		OP_KTH_END
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic load_fail;
		logic last_level;
		logic query_fail;
		logic scan_end;
		logic scan_hit;
		logic lift_equal;
		logic level_zero;
		logic kth_go;
	} dp_status_t;

endpackage

/* src/lcabl_datapath.sv */
// Datapath of the lowest-common-ancestor block: jump, depth and loaded-flag memories,
// working registers and result registers. Depends on lcabl_pkg.
module lcabl_datapath #(
	parameter int MAX_NODES = lcabl_pkg::DEF_MAX_NODES,
	parameter int JUMP_LEVELS = lcabl_pkg::DEF_JUMP_LEVELS
) (
	input  logic clk,
	input  logic arst_n,
	input  lcabl_pkg::ctl_cmd_t ctl,
	output lcabl_pkg::dp_status_t status,
	input  logic [lcabl_pkg::NODE_W-1:0] node,
	input  logic [lcabl_pkg::NODE_W-1:0] parent,
	input  logic has_parent,
	input  logic [lcabl_pkg::NODE_W-1:0] first_node,
	input  logic [lcabl_pkg::NODE_W-1:0] second_node,
	input  logic [lcabl_pkg::DIST_W-1:0] distance,
	output logic ok,
	output logic [lcabl_pkg::NODE_W-1:0] common_ancestor,
	output logic [lcabl_pkg::PATH_W-1:0] path_length,
	output logic second_is_ancestor,
	output logic [lcabl_pkg::NODE_W-1:0] kth_node,
	output logic kth_valid
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LW = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
	localparam int JDEPTH = MAX_NODES * (2 ** LW);
	localparam int NW = lcabl_pkg::NODE_W;
	localparam int DW = lcabl_pkg::DEPTH_W;
	localparam int EW = lcabl_pkg::ENTRY_W;
	localparam int KW = lcabl_pkg::LVL_W;

	logic [EW-1:0] jump_mem [0:JDEPTH-1];
	logic [DW-1:0] depth_mem [0:MAX_NODES-1];
	logic flag_mem [0:MAX_NODES-1];

	logic [EW-1:0] jump_rd_q;
	logic [DW-1:0] depth_rd_q;
	logic flag_rd_q;

	logic [NW-1:0] node_q, par_q, a_q, b_q, u_q, v_q, eu_node_q;
	logic [lcabl_pkg::DIST_W-1:0] dist_q, bits_q;
	logic hasp_q, la_q, reached_q, broken_q, eu_valid_q;
	logic [DW-1:0] da_q, db_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] clr_q;

	logic ok_q, sia_q, kv_q;
	logic [NW-1:0] lca_q, kth_q;
	logic [lcabl_pkg::PATH_W-1:0] path_q;

	logic [AW-1:0] jr_node, dr_addr;
	logic [LW-1:0] jr_lvl;
	logic jw_en, dw_en, fw_en, fw_data;
	logic [AW-1:0] fw_addr;
	logic [EW-1:0] jw_data;
	logic [DW-1:0] dep_new;
	logic node_in, par_in, a_in, b_in;
	logic [12:0] path_sum;

	assign node_in = 32'(node_q) < MAX_NODES;
	assign par_in = 32'(par_q) < MAX_NODES;
	assign a_in = 32'(a_q) < MAX_NODES;
	assign b_in = 32'(b_q) < MAX_NODES;

	assign status.clr_last = (clr_q == AW'(MAX_NODES - 1));
	assign status.load_fail = !node_in || (hasp_q && !(par_in && flag_rd_q));
	assign status.last_level = (k_q == KW'(JUMP_LEVELS - 1));
	assign status.query_fail = !(la_q && b_in && flag_rd_q);
	assign status.scan_end = (bits_q == '0);
	assign status.scan_hit = bits_q[0] && (32'(k_q) < JUMP_LEVELS);
	assign status.lift_equal = (u_q == v_q);
	assign status.level_zero = (k_q == '0);
	assign status.kth_go = (dist_q <= da_q);

	always_comb begin
		jr_node = (ctl.op == lcabl_pkg::OP_DESC_V) ? AW'(v_q) : AW'(u_q);
		jr_lvl = (ctl.op == lcabl_pkg::OP_FIN_RD) ? '0 : k_q[LW-1:0];
		case (ctl.op)
			lcabl_pkg::OP_L_RD: dr_addr = AW'(par_q);
			lcabl_pkg::OP_Q_RDB: dr_addr = AW'(b_q);
			lcabl_pkg::OP_DL_RD: dr_addr = AW'(lca_q);
			default: dr_addr = AW'(a_q);
		endcase
		dep_new = hasp_q ? ((depth_rd_q == lcabl_pkg::DEPTH_LIMIT) ? lcabl_pkg::DEPTH_LIMIT
			: depth_rd_q + 1'b1) : '0;
		jw_en = (ctl.op == lcabl_pkg::OP_L_STEP);
		jw_data = broken_q ? '0 : {1'b1, u_q};
		dw_en = (ctl.op == lcabl_pkg::OP_L_CHK) && !status.load_fail;
		fw_en = dw_en || (ctl.op == lcabl_pkg::OP_CLEAR);
		fw_addr = dw_en ? AW'(node_q) : clr_q;
		fw_data = dw_en;
		path_sum = 13'(da_q) + 13'(db_q) - {2'b00, depth_rd_q, 1'b0};
	end

	// Read-first memories: a level read in the same cycle as its write sees the old entry.
	always_ff @(posedge clk) begin
		if (jw_en) begin
			jump_mem[{AW'(node_q), k_q[LW-1:0]}] <= jw_data;
		end
		jump_rd_q <= jump_mem[{jr_node, jr_lvl}];
		if (dw_en) begin
			depth_mem[AW'(node_q)] <= dep_new;
		end
		depth_rd_q <= depth_mem[dr_addr];
		if (fw_en) begin
			flag_mem[fw_addr] <= fw_data;
		end
		flag_rd_q <= flag_mem[dr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.op == lcabl_pkg::OP_CLEAR && !status.clr_last) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			lcabl_pkg::OP_CAPTURE: begin
				node_q <= node;
				par_q <= parent;
				hasp_q <= has_parent;
				a_q <= first_node;
				b_q <= second_node;
				dist_q <= distance;
			end
			lcabl_pkg::OP_L_CHK: begin
				u_q <= par_q;
				k_q <= '0;
				broken_q <= !hasp_q;
				ok_q <= !status.load_fail;
				lca_q <= '0;
				path_q <= '0;
				sia_q <= 1'b0;
				kth_q <= '0;
				kv_q <= 1'b0;
			end
			lcabl_pkg::OP_L_NEXT: begin
				if (!broken_q) begin
					if (jump_rd_q[EW-1]) begin
						u_q <= jump_rd_q[NW-1:0];
					end else begin
						broken_q <= 1'b1;
					end
				end
				k_q <= k_q + 1'b1;
			end
			lcabl_pkg::OP_Q_RDB: begin
				la_q <= a_in && flag_rd_q;
				da_q <= depth_rd_q;
			end
			lcabl_pkg::OP_Q_CHK: begin
				db_q <= depth_rd_q;
				ok_q <= !status.query_fail;
				lca_q <= '0;
				path_q <= '0;
				sia_q <= 1'b0;
				kth_q <= '0;
				kv_q <= 1'b0;
				k_q <= '0;
				reached_q <= 1'b1;
				if (da_q < depth_rd_q) begin
					u_q <= b_q;
					v_q <= a_q;
					bits_q <= depth_rd_q - da_q;
				end else begin
					u_q <= a_q;
					v_q <= b_q;
					bits_q <= da_q - depth_rd_q;
				end
			end
			lcabl_pkg::OP_SCAN: begin
				if (!status.scan_end && !status.scan_hit) begin
					if (bits_q[0]) begin
						reached_q <= 1'b0;
					end
					bits_q <= bits_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			lcabl_pkg::OP_APPLY: begin
				if (jump_rd_q[EW-1]) begin
					u_q <= jump_rd_q[NW-1:0];
				end else begin
					reached_q <= 1'b0;
				end
				bits_q <= bits_q >> 1;
				k_q <= k_q + 1'b1;
			end
			lcabl_pkg::OP_LIFT_END: begin
				sia_q <= (da_q >= db_q) && reached_q && (u_q == v_q);
				lca_q <= u_q;
				k_q <= KW'(JUMP_LEVELS - 1);
			end
			lcabl_pkg::OP_DESC_V: begin
				eu_valid_q <= jump_rd_q[EW-1];
				eu_node_q <= jump_rd_q[NW-1:0];
			end
			lcabl_pkg::OP_DESC_CMP: begin
				if (eu_valid_q && jump_rd_q[EW-1] && eu_node_q != jump_rd_q[NW-1:0]) begin
					u_q <= eu_node_q;
					v_q <= jump_rd_q[NW-1:0];
				end
				if (!status.level_zero) begin
					k_q <= k_q - 1'b1;
				end
			end
			lcabl_pkg::OP_FIN: begin
				lca_q <= jump_rd_q[EW-1] ? jump_rd_q[NW-1:0] : u_q;
			end
			lcabl_pkg::OP_DL: begin
				path_q <= path_sum[12] ? '0 : path_sum[10:0];
				u_q <= a_q;
				bits_q <= dist_q;
				k_q <= '0;
				reached_q <= 1'b1;
			end
			lcabl_pkg::OP_KTH_END: begin
				if (reached_q) begin
					kth_q <= u_q;
					kv_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ok = ok_q;
	assign common_ancestor = lca_q;
	assign path_length = path_q;
	assign second_is_ancestor = sia_q;
	assign kth_node = kth_q;
	assign kth_valid = kv_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == lcabl_pkg::OP_APPLY |=> k_q == $past(k_q) + 1'b1)
		else $error("level counter did not advance after a jump");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == lcabl_pkg::OP_L_STEP |-> 32'(k_q) < JUMP_LEVELS)
		else $error("load wrote a level beyond the table");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == lcabl_pkg::OP_KTH_END && kv_q |-> ok_q)
		else $error("ancestor reported for a failed query");

endmodule

/* src/lcabl_ctrl.sv */
// Controller state machine of the lowest-common-ancestor block: sequences loads,
// queries and the flag clearing pass. Depends on lcabl_pkg.
module lcabl_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	output logic out_valid,
	input  logic out_stall,
	output lcabl_pkg::ctl_cmd_t ctl,
	input  lcabl_pkg::dp_status_t status
);

	typedef enum logic [20:0] {
		S_CLEAR    = 21'd1 << 0,
		S_IDLE     = 21'd1 << 1,
		S_L_RD     = 21'd1 << 2,
		S_L_CHK    = 21'd1 << 3,
		S_L_STEP   = 21'd1 << 4,
		S_L_NEXT   = 21'd1 << 5,
		S_Q_RDA    = 21'd1 << 6,
		S_Q_RDB    = 21'd1 << 7,
		S_Q_CHK    = 21'd1 << 8,
		S_SCAN     = 21'd1 << 9,
		S_APPLY    = 21'd1 << 10,
		S_LIFT_END = 21'd1 << 11,
		S_DESC_U   = 21'd1 << 12,
		S_DESC_V   = 21'd1 << 13,
		S_DESC_CMP = 21'd1 << 14,
		S_FIN_RD   = 21'd1 << 15,
		S_FIN      = 21'd1 << 16,
		S_DL_RD    = 21'd1 << 17,
		S_DL       = 21'd1 << 18,
		S_KTH_END  = 21'd1 << 19,
		S_OUT      = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;
	logic kth_phase_q, kth_phase_d;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		kth_phase_d = kth_phase_q;
		ctl.op = lcabl_pkg::OP_NONE;
		case (state_q)
			S_CLEAR: begin
				ctl.op = lcabl_pkg::OP_CLEAR;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.op = lcabl_pkg::OP_CAPTURE;
					state_d = (cmd == lcabl_pkg::CMD_QUERY) ? S_Q_RDA : S_L_RD;
				end
			end
			S_L_RD: begin
				ctl.op = lcabl_pkg::OP_L_RD;
				state_d = S_L_CHK;
			end
			S_L_CHK: begin
				ctl.op = lcabl_pkg::OP_L_CHK;
				state_d = status.load_fail ? S_OUT : S_L_STEP;
			end
			S_L_STEP: begin
				ctl.op = lcabl_pkg::OP_L_STEP;
				state_d = S_L_NEXT;
			end
			S_L_NEXT: begin
				ctl.op = lcabl_pkg::OP_L_NEXT;
				state_d = status.last_level ? S_OUT : S_L_STEP;
			end
			S_Q_RDA: begin
				ctl.op = lcabl_pkg::OP_Q_RDA;
				state_d = S_Q_RDB;
			end
			S_Q_RDB: begin
				ctl.op = lcabl_pkg::OP_Q_RDB;
				state_d = S_Q_CHK;
			end
			S_Q_CHK: begin
				ctl.op = lcabl_pkg::OP_Q_CHK;
				kth_phase_d = 1'b0;
				state_d = status.query_fail ? S_OUT : S_SCAN;
			end
			S_SCAN: begin
				ctl.op = lcabl_pkg::OP_SCAN;
				if (status.scan_end) begin
					state_d = kth_phase_q ? S_KTH_END : S_LIFT_END;
				end else if (status.scan_hit) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				ctl.op = lcabl_pkg::OP_APPLY;
				state_d = S_SCAN;
			end
			S_LIFT_END: begin
				ctl.op = lcabl_pkg::OP_LIFT_END;
				state_d = status.lift_equal ? S_DL_RD : S_DESC_U;
			end
			S_DESC_U: begin
				ctl.op = lcabl_pkg::OP_DESC_U;
				state_d = S_DESC_V;
			end
			S_DESC_V: begin
				ctl.op = lcabl_pkg::OP_DESC_V;
				state_d = S_DESC_CMP;
			end
			S_DESC_CMP: begin
				ctl.op = lcabl_pkg::OP_DESC_CMP;
				state_d = status.level_zero ? S_FIN_RD : S_DESC_U;
			end
			S_FIN_RD: begin
				ctl.op = lcabl_pkg::OP_FIN_RD;
				state_d = S_FIN;
			end
			S_FIN: begin
				ctl.op = lcabl_pkg::OP_FIN;
				state_d = S_DL_RD;
			end
			S_DL_RD: begin
				ctl.op = lcabl_pkg::OP_DL_RD;
				state_d = S_DL;
			end
			S_DL: begin
				ctl.op = lcabl_pkg::OP_DL;
				kth_phase_d = 1'b1;
				state_d = status.kth_go ? S_SCAN : S_OUT;
			end
			S_KTH_END: begin
				ctl.op = lcabl_pkg::OP_KTH_END;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kth_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kth_phase_q <= kth_phase_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result shown in the cycle after a request was taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR)
		else $error("clearing pass entered again");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a result waits");

endmodule

/* src/lca_binary_lifting.sv */
// Top level of the lowest-common-ancestor block using binary lifting.
// Instantiates lcabl_ctrl and lcabl_datapath; depends on lcabl_pkg.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  cmd node parent has_parent first_node second_node distance
//   output    out_valid/ out_stall ok common_ancestor path_length second_is_ancestor
//                                  kth_node kth_valid
//
// An accepted load reads the parent's depth and loaded flag, checks them, then makes one memory
// read and one write per level of the jump table; a refused load ends after the check. A query
// ends after the check when a node is not loaded; otherwise it makes up to two lifts over the
// ten distance bits (a jump for each set bit) and, when the lifted nodes differ, a descent that
// reads both nodes' entries at each level, all through the single read port of the jump memory.
// After reset a clearing pass over all MAX_NODES entries resets the loaded flags; no request is
// taken until it ends. One request is worked on at a time; a result held by out_stall
// keeps the input stalled.
module lca_binary_lifting #(
	parameter int MAX_NODES = lcabl_pkg::DEF_MAX_NODES,
	parameter int JUMP_LEVELS = lcabl_pkg::DEF_JUMP_LEVELS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [lcabl_pkg::NODE_W-1:0] node,
	input  logic [lcabl_pkg::NODE_W-1:0] parent,
	input  logic has_parent,
	input  logic [lcabl_pkg::NODE_W-1:0] first_node,
	input  logic [lcabl_pkg::NODE_W-1:0] second_node,
	input  logic [lcabl_pkg::DIST_W-1:0] distance,
	output logic out_valid,
	input  logic out_stall,
	output logic ok,
	output logic [lcabl_pkg::NODE_W-1:0] common_ancestor,
	output logic [lcabl_pkg::PATH_W-1:0] path_length,
	output logic second_is_ancestor,
	output logic [lcabl_pkg::NODE_W-1:0] kth_node,
	output logic kth_valid
);

	lcabl_pkg::ctl_cmd_t ctl;
	lcabl_pkg::dp_status_t status;

	lcabl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ctl(ctl),
		.status(status)
	);

	lcabl_datapath #(
		.MAX_NODES(MAX_NODES),
		.JUMP_LEVELS(JUMP_LEVELS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.status(status),
		.node(node),
		.parent(parent),
		.has_parent(has_parent),
		.first_node(first_node),
		.second_node(second_node),
		.distance(distance),
		.ok(ok),
		.common_ancestor(common_ancestor),
		.path_length(path_length),
		.second_is_ancestor(second_is_ancestor),
		.kth_node(kth_node),
		.kth_valid(kth_valid)
	);

endmodule

/* sim/tb_lca_binary_lifting.sv */
// Self-checking testbench for lca_binary_lifting: loads rooted trees, queries them and
// compares every result with a binary-lifting predictor kept inside the bench.
// Depends on lcabl_pkg and the lca_binary_lifting RTL.
`timescale 1ns / 1ps

module tb_lca_binary_lifting;

	localparam int NODE_W = lcabl_pkg::NODE_W;
	localparam int ENTRY_W = lcabl_pkg::ENTRY_W;
	localparam int DEPTH_W = lcabl_pkg::DEPTH_W;
	localparam int PATH_W = lcabl_pkg::PATH_W;
	localparam int DIST_W = lcabl_pkg::DIST_W;
	localparam int N_NODES = lcabl_pkg::DEF_MAX_NODES;
	localparam int N_LEVELS = lcabl_pkg::DEF_JUMP_LEVELS;
	localparam int CHAIN_LEN = 300;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		logic ok;
		logic [NODE_W-1:0] common_ancestor;
		logic [PATH_W-1:0] path_length;
		logic second_is_ancestor;
		logic [NODE_W-1:0] kth_node;
		logic kth_valid;
	} lca_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = lcabl_pkg::CMD_LOAD;
	logic [NODE_W-1:0] node = '0;
	logic [NODE_W-1:0] parent = '0;
	logic has_parent = 1'b0;
	logic [NODE_W-1:0] first_node = '0;
	logic [NODE_W-1:0] second_node = '0;
	logic [DIST_W-1:0] distance = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ok;
	logic [NODE_W-1:0] common_ancestor;
	logic [PATH_W-1:0] path_length;
	logic second_is_ancestor;
	logic [NODE_W-1:0] kth_node;
	logic kth_valid;

	// Shadow copy of the tree held by the block.
	logic [ENTRY_W-1:0] jump_shadow [N_NODES][N_LEVELS];
	logic [DEPTH_W-1:0] depth_shadow [N_NODES];
	bit node_loaded [N_NODES];
	logic [NODE_W-1:0] loaded_list [$];

	lca_result_t pending_results [$];
	int mismatch_count = 0;
	int load_count = 0;
	int query_count = 0;
	int result_count = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	lca_binary_lifting i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [NODE_W-1:0] climb_up(input logic [NODE_W-1:0] n,
			input int steps, output bit reached);
		logic [ENTRY_W-1:0] e;
		reached = 1'b1;
		for (int k = 0; k < N_LEVELS; k++) begin
			if (steps[k]) begin
				e = jump_shadow[n][k];
				if (!e[NODE_W])
					reached = 1'b0;
				else
					n = e[NODE_W-1:0];
			end
		end
		// Distances wider than the table cannot be reached.
		if ((steps >> N_LEVELS) != 0)
			reached = 1'b0;
		return n;
	endfunction

	function automatic logic [NODE_W-1:0] meet_point(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		int da, db;
		logic [NODE_W-1:0] u, v;
		logic [ENTRY_W-1:0] eu, ev;
		bit reached;
		da = depth_shadow[a];
		db = depth_shadow[b];
		u = (da < db) ? b : a;
		v = (da < db) ? a : b;
		u = climb_up(u, (da > db) ? da - db : db - da, reached);
		if (u == v)
			return u;
		for (int k = N_LEVELS - 1; k >= 0; k--) begin
			eu = jump_shadow[u][k];
			ev = jump_shadow[v][k];
			if (eu[NODE_W] && ev[NODE_W] && eu[NODE_W-1:0] != ev[NODE_W-1:0]) begin
				u = eu[NODE_W-1:0];
				v = ev[NODE_W-1:0];
			end
		end
		eu = jump_shadow[u][0];
		return eu[NODE_W] ? eu[NODE_W-1:0] : u;
	endfunction

	function automatic lca_result_t apply_request(input logic c, input logic [NODE_W-1:0] nd,
			input logic [NODE_W-1:0] par, input logic hp, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b, input logic [DIST_W-1:0] steps);
		lca_result_t r;
		logic [ENTRY_W-1:0] row [N_LEVELS];
		logic [ENTRY_W-1:0] e;
		logic [NODE_W-1:0] d, lca, up;
		int dep, da, db, path;
		bit reached;
		r = '{default: '0};
		if (c == lcabl_pkg::CMD_LOAD) begin
			if (hp && !node_loaded[par])
				return r;
			foreach (row[k]) row[k] = '0;
			dep = 0;
			if (hp) begin
				dep = depth_shadow[par] + 1;
				if (dep > lcabl_pkg::DEPTH_LIMIT)
					dep = lcabl_pkg::DEPTH_LIMIT;
				d = par;
				for (int k = 0; k < N_LEVELS; k++) begin
					row[k] = {1'b1, d};
					e = jump_shadow[d][k];
					if (!e[NODE_W])
						break;
					d = e[NODE_W-1:0];
				end
			end
			foreach (row[k]) jump_shadow[nd][k] = row[k];
			depth_shadow[nd] = dep[DEPTH_W-1:0];
			if (!node_loaded[nd])
				loaded_list.push_back(nd);
			node_loaded[nd] = 1'b1;
			r.ok = 1'b1;
			return r;
		end
		if (!node_loaded[a] || !node_loaded[b])
			return r;
		da = depth_shadow[a];
		db = depth_shadow[b];
		lca = meet_point(a, b);
		path = da + db - 2 * int'(depth_shadow[lca]);
		if (path < 0)
			path = 0;
		r.ok = 1'b1;
		r.common_ancestor = lca;
		r.path_length = path[PATH_W-1:0];
		if (da >= db) begin
			up = climb_up(a, da - db, reached);
			r.second_is_ancestor = reached && up == b;
		end
		if (int'(steps) <= da) begin
			up = climb_up(a, int'(steps), reached);
			if (reached) begin
				r.kth_node = up;
				r.kth_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// Called at a falling edge; leaves valid high so back-to-back requests need no toggle.
	task automatic send_req(input logic c, input logic [NODE_W-1:0] nd,
			input logic [NODE_W-1:0] par, input logic hp, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b, input logic [DIST_W-1:0] steps);
		if (!no_idle && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		cmd <= c;
		node <= nd;
		parent <= par;
		has_parent <= hp;
		first_node <= a;
		second_node <= b;
		distance <= steps;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_request(c, nd, par, hp, a, b, steps));
		if (c == lcabl_pkg::CMD_LOAD)
			load_count++;
		else
			query_count++;
		@(negedge clk);
	endtask

	task automatic load_node(input logic [NODE_W-1:0] nd, input logic [NODE_W-1:0] par,
			input logic hp);
		send_req(lcabl_pkg::CMD_LOAD, nd, par, hp, NODE_W'($urandom), NODE_W'($urandom),
				DIST_W'($urandom));
	endtask

	task automatic query_pair(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
			input logic [DIST_W-1:0] steps);
		send_req(lcabl_pkg::CMD_QUERY, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
				a, b, steps);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (120) @(negedge clk);
	endtask

	function automatic logic [NODE_W-1:0] pick_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	task automatic test_empty_tree();
		query_pair(10'd0, 10'd1023, 10'd0);
		load_node(10'd5, 10'd4, 1'b1);
		load_node(10'd1023, 10'd0, 1'b1);
		drain_results();
	endtask

	task automatic test_small_trees();
		load_node(10'd0, 10'd0, 1'b0);
		load_node(10'd1023, 10'd0, 1'b1);
		load_node(10'd682, 10'd1023, 1'b1);
		load_node(10'd341, 10'd1023, 1'b1);
		load_node(10'd7, 10'd682, 1'b1);
		load_node(10'd600, 10'd600, 1'b0);
		load_node(10'd601, 10'd600, 1'b1);
		// A node given itself as parent is a legal reload.
		load_node(10'd601, 10'd601, 1'b1);
		query_pair(10'd7, 10'd341, 10'd3);
		query_pair(10'd7, 10'd0, 10'd1023);
		query_pair(10'd0, 10'd7, 10'd0);
		query_pair(10'd7, 10'd7, 10'd4);
		query_pair(10'd7, 10'd601, 10'd2);
		query_pair(10'd601, 10'd7, 10'd1);
		query_pair(10'd7, 10'd9, 10'd1);
		// Reloading moves a subtree root without touching the rows below it.
		load_node(10'd682, 10'd600, 1'b1);
		query_pair(10'd7, 10'd601, 10'd3);
		query_pair(10'd682, 10'd1023, 10'd1);
		drain_results();
	endtask

	task automatic test_deep_chain();
		load_node(10'd0, 10'd0, 1'b0);
		for (int i = 1; i < CHAIN_LEN; i++)
			load_node(i[NODE_W-1:0], i[NODE_W-1:0] - 10'd1, 1'b1);
		// Hanging the old root under the end of the chain reloads it with a deep parent.
		load_node(10'd0, 10'd299, 1'b1);
		query_pair(10'd299, 10'd1, 10'd298);
		query_pair(10'd299, 10'd1, 10'd299);
		query_pair(10'd150, 10'd280, 10'd149);
		query_pair(10'd0, 10'd299, 10'd299);
		for (int i = 0; i < 12; i++)
			query_pair(NODE_W'($urandom), NODE_W'($urandom), DIST_W'($urandom));
		drain_results();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		no_idle = 1'b1;
		for (int i = 0; i < 12; i++)
			query_pair(pick_loaded(), pick_loaded(), DIST_W'($urandom_range(20)));
		no_idle = 1'b0;
		drain_results();
	endtask

	task automatic test_random(input int count);
		logic [NODE_W-1:0] a;
		int sel;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 3 && i < count / 2);
			sel = $urandom_range(99);
			if (sel < 40)
				load_node(NODE_W'($urandom), pick_loaded(), 1'b1);
			else if (sel < 45)
				load_node(NODE_W'($urandom), NODE_W'($urandom), 1'b0);
			else if (sel < 85) begin
				a = pick_loaded();
				query_pair(a, pick_loaded(),
						DIST_W'($urandom_range(0, depth_shadow[a] + 2)));
			end else
				send_req(1'($urandom), NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
						NODE_W'($urandom), NODE_W'($urandom), DIST_W'($urandom));
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (no_idle)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 25);
	end

	always @(posedge clk) begin
		lca_result_t want;
		if (out_valid && !out_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Result with no request outstanding at %0t", $realtime);
			end else begin
				want = pending_results.pop_front();
				if (want.ok !== ok || want.common_ancestor !== common_ancestor ||
						want.path_length !== path_length ||
						want.second_is_ancestor !== second_is_ancestor ||
						want.kth_node !== kth_node || want.kth_valid !== kth_valid) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch at %0t: expected ok=%0b lca=%0d path=%0d anc=%0b",
								$realtime, want.ok, want.common_ancestor,
								want.path_length, want.second_is_ancestor);
						$display("  kth=%0d kv=%0b, got ok=%0b lca=%0d path=%0d anc=%0b",
								want.kth_node, want.kth_valid, ok, common_ancestor,
								path_length, second_is_ancestor);
						$display("  kth=%0d kv=%0b", kth_node, kth_valid);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding",
					pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		foreach (node_loaded[i]) begin
			node_loaded[i] = 1'b0;
			depth_shadow[i] = '0;
		end
		foreach (jump_shadow[i, k]) jump_shadow[i][k] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_tree();
		test_small_trees();
		test_deep_chain();
		test_backpressure();
		test_random(200);
		if (pending_results.size() != 0)
			mismatch_count++;
		$display("Covered %0d loads and %0d queries over a long chain and random forests;",
				load_count, query_count);
		$display("%0d results checked, %0d mismatches.", result_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
